// File: rtl/core/mandelbrot_supersampled_pixel_top_macros.svh
// Assertion macros used by the mandelbrot pixel back end (mbs_back).
// Needs a clk and an active-low rst_n in the scope of use.
`ifndef MANDELBROT_SUPERSAMPLED_PIXEL_TOP_MACROS_SVH
`define MANDELBROT_SUPERSAMPLED_PIXEL_TOP_MACROS_SVH

// property must hold at every clock edge out of reset
`define MBS_ASSERT_HOLDS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mbs assertion failed");

// consequent must hold in the cycle after the antecedent
`define MBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbs assertion failed");

`endif

// File: rtl/core/mbs_pkg.sv
// Shared types, constants and helpers of the mandelbrot pixel block.
// No dependencies.
`default_nettype none

package mbs_pkg;

    localparam int DEF_PALETTE_DEPTH = 1024;
    localparam int DEF_COORD_BITS    = 64;
    localparam int DEF_PIXEL_BITS    = 12;
    localparam int PIXEL_MAX_BITS    = 16;

    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int COUNT_W      = 11;
    localparam int ENTRY_IDX_W  = 10;
    localparam int COLOR_W      = 8;
    localparam int RGB_W        = 3 * COLOR_W;
    localparam int PITCH_W      = 63;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_REAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_IMAG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 3'd4;

    localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 11'd1000;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    typedef struct packed {
        logic [63:0]         origin_real;
        logic [63:0]         origin_imag;
        logic [PITCH_W-1:0]  pitch_real;
        logic [PITCH_W-1:0]  pitch_imag;
        logic [COUNT_W-1:0]  max_iter;
    } cfg_t;

    typedef struct packed {
        logic                      kind;
        logic                      idx_ok;
        logic [PIXEL_MAX_BITS-1:0] px;
        logic [PIXEL_MAX_BITS-1:0] py;
        logic [ENTRY_IDX_W-1:0]    idx;
        logic [RGB_W-1:0]          rgb;
    } cmd_t;

    typedef struct packed {
        logic               go;
        logic               coord_mode;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic               ovf;
        logic signed [63:0] res;
    } mul_rsp_t;

    // sub-pixel offset in eighths of a pitch
    function automatic logic signed [3:0] sample_offset(input logic [1:0] k);
        logic signed [3:0] r;
        unique case (k)
            2'd0: r = -4'sd3;
            2'd1: r = -4'sd1;
            2'd2: r = 4'sd1;
            default: r = 4'sd3;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mbs_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on mbs_pkg.
`default_nettype none

module mbs_front #(
    parameter int PALETTE_DEPTH = mbs_pkg::DEF_PALETTE_DEPTH,
    parameter int PIXEL_BITS    = mbs_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                in_op,
    input  wire logic [PIXEL_BITS-1:0]               in_px,
    input  wire logic [PIXEL_BITS-1:0]               in_py,
    input  wire logic [mbs_pkg::ENTRY_IDX_W-1:0]     in_idx,
    input  wire logic [mbs_pkg::RGB_W-1:0]           in_rgb,
    output logic                                     cmd_valid,
    output mbs_pkg::cmd_t                            cmd,
    input  wire logic                                cmd_pop
);

    localparam int CMP_W = 14;

    mbs_pkg::cmd_t q_mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    q_cnt_reg, q_cnt_next;
    mbs_pkg::cmd_t new_cmd;
    logic          push, pop;

    always_comb
    begin
        new_cmd.kind   = in_op;
        // loads beyond the palette are dropped by the back end
        new_cmd.idx_ok = (CMP_W'(in_idx) < CMP_W'(PALETTE_DEPTH));
        new_cmd.px     = mbs_pkg::PIXEL_MAX_BITS'(in_px);
        new_cmd.py     = mbs_pkg::PIXEL_MAX_BITS'(in_py);
        new_cmd.idx    = in_idx;
        new_cmd.rgb    = in_rgb;
    end

    assign in_ready  = (q_cnt_reg != 2'd2);
    assign cmd_valid = (q_cnt_reg != 2'd0);
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            q_cnt_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mbs_fixmul.sv
// Shared multi-cycle signed fixed point multiplier (four 32x32 partials).
// Floors a*b / 2^s, s = 3 in coordinate mode, else the fraction width. Needs mbs_pkg.
`default_nettype none

module mbs_fixmul #(
    parameter int COORD_BITS = mbs_pkg::DEF_COORD_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mbs_pkg::mul_req_t req,
    output mbs_pkg::mul_rsp_t      rsp
);

    localparam int FRAC = COORD_BITS - 6;
    localparam logic [127:0] CMAX128 = (128'd1 << (COORD_BITS - 1)) - 128'd1;
    localparam logic [127:0] FRAC_RND = (128'd1 << FRAC) - 128'd1;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_RND  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic [1:0]   ph_reg;
    logic [2:0]   step_reg;
    logic [63:0]  am_reg, bm_reg;
    logic         neg_reg, cm_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pps_reg;
    logic [127:0] acc_reg;
    logic [63:0]  res_reg;
    logic         ovf_reg, done_reg;

    logic [31:0]  ah, bh;
    logic [1:0]   sh;
    logic [63:0]  pp_next;
    logic [127:0] pp_wide, m_val, lim;

    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0: begin ah = am_reg[31:0];  bh = bm_reg[31:0];  sh = 2'd0; end
            2'd1: begin ah = am_reg[31:0];  bh = bm_reg[63:32]; sh = 2'd1; end
            2'd2: begin ah = am_reg[63:32]; bh = bm_reg[31:0];  sh = 2'd1; end
            default: begin ah = am_reg[63:32]; bh = bm_reg[63:32]; sh = 2'd2; end
        endcase
        pp_next = 64'(ah) * 64'(bh);
        unique case (pps_reg)
            2'd0: pp_wide = {64'd0, pp_reg};
            2'd1: pp_wide = {32'd0, pp_reg, 32'd0};
            default: pp_wide = {pp_reg, 64'd0};
        endcase
        m_val = cm_reg ? (acc_reg >> 3) : (acc_reg >> FRAC);
        lim   = CMAX128 + 128'(neg_reg);
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.res  = $signed(res_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            step_reg <= 3'd0;
            am_reg   <= 64'd0;
            bm_reg   <= 64'd0;
            neg_reg  <= 1'b0;
            cm_reg   <= 1'b0;
            pp_reg   <= 64'd0;
            pps_reg  <= 2'd0;
            acc_reg  <= 128'd0;
            res_reg  <= 64'd0;
            ovf_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (ph_reg)
                PH_IDLE:
                begin
                    if (req.go)
                    begin
                        am_reg   <= req.a[63] ? 64'(-req.a) : 64'(req.a);
                        bm_reg   <= req.b[63] ? 64'(-req.b) : 64'(req.b);
                        neg_reg  <= req.a[63] ^ req.b[63];
                        cm_reg   <= req.coord_mode;
                        acc_reg  <= 128'd0;
                        step_reg <= 3'd0;
                        ph_reg   <= PH_MUL;
                    end
                end
                PH_MUL:
                begin
                    // partial product of one step is summed in the next
                    if (step_reg != 3'd4)
                    begin
                        pp_reg  <= pp_next;
                        pps_reg <= sh;
                    end
                    if (step_reg != 3'd0)
                    begin
                        acc_reg <= acc_reg + pp_wide;
                    end
                    if (step_reg == 3'd4)
                    begin
                        ph_reg <= PH_RND;
                    end
                    step_reg <= step_reg + 3'd1;
                end
                PH_RND:
                begin
                    // bias toward minus infinity for negative products
                    if (neg_reg)
                    begin
                        acc_reg <= acc_reg + (cm_reg ? 128'd7 : FRAC_RND);
                    end
                    ph_reg <= PH_FIN;
                end
                default:
                begin
                    res_reg  <= neg_reg ? (64'd0 - m_val[63:0]) : m_val[63:0];
                    ovf_reg  <= (m_val > lim);
                    done_reg <= 1'b1;
                    ph_reg   <= PH_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mbs_back.sv
// Back end: palette store, sample sequencer, escape iteration, color averaging.
// Depends on mbs_pkg, mbs_fixmul and the assertion macro header.
`default_nettype none
`include "mandelbrot_supersampled_pixel_top_macros.svh"

module mbs_back #(
    parameter int PALETTE_DEPTH = mbs_pkg::DEF_PALETTE_DEPTH,
    parameter int COORD_BITS    = mbs_pkg::DEF_COORD_BITS,
    parameter int PIXEL_BITS    = mbs_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mbs_pkg::cfg_t                 cfg,
    input  wire logic                          cmd_valid,
    input  wire mbs_pkg::cmd_t                 cmd,
    output logic                               cmd_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [mbs_pkg::RGB_W-1:0]          m_rgb,
    output logic                               m_refined
);

    localparam int FRAC  = COORD_BITS - 6;
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam int CMP_W = 14;
    localparam int CW    = mbs_pkg::COUNT_W;
    localparam logic [63:0] CMASK = {64{1'b1}} >> (64 - COORD_BITS);
    localparam logic signed [65:0] CMAX66 = (66'sd1 <<< (COORD_BITS - 1)) - 66'sd1;
    localparam logic signed [65:0] CMIN66 = -(66'sd1 <<< (COORD_BITS - 1));
    localparam logic [64:0] LIM10 = 65'd10 << FRAC;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CGO     = 4'd1;
    localparam logic [3:0] ST_MWAIT   = 4'd2;
    localparam logic [3:0] ST_SNEXT   = 4'd3;
    localparam logic [3:0] ST_LOOPCHK = 4'd4;
    localparam logic [3:0] ST_ADD1    = 4'd5;
    localparam logic [3:0] ST_ADD2    = 4'd6;
    localparam logic [3:0] ST_ESC     = 4'd7;
    localparam logic [3:0] ST_SDONE   = 4'd8;
    localparam logic [3:0] ST_CMP     = 4'd9;
    localparam logic [3:0] ST_PREAD   = 4'd10;
    localparam logic [3:0] ST_PACC    = 4'd11;
    localparam logic [3:0] ST_OUTW    = 4'd12;

    localparam logic [2:0] MOP_COORD = 3'd0;
    localparam logic [2:0] MOP_P0    = 3'd1;
    localparam logic [2:0] MOP_Q0    = 3'd2;
    localparam logic [2:0] MOP_S     = 3'd3;
    localparam logic [2:0] MOP_P2    = 3'd4;
    localparam logic [2:0] MOP_Q2    = 3'd5;

    function automatic logic signed [63:0] wrap_cb(input logic [63:0] v);
        return $signed(v[COORD_BITS-1] ? (v | ~CMASK) : (v & CMASK));
    endfunction

    function automatic logic signed [65:0] sx66(input logic signed [63:0] v);
        return {{2{v[63]}}, v};
    endfunction

    logic [3:0]              state_reg;
    logic [2:0]              mop_reg;
    logic [PIXEL_BITS-1:0]   px_reg, py_reg;
    logic [2:0]              cidx_reg;
    logic signed [63:0]      xr_reg [4];
    logic signed [63:0]      yi_reg [4];
    logic [CW-1:0]           cnt_reg [4];
    logic                    refine_reg;
    logic [3:0]              sidx_reg;
    logic signed [63:0]      cr_reg, ci_reg, zr_reg, zi_reg, p_reg, q_reg;
    logic signed [63:0]      dq_reg, s2_reg, nr_reg, ni_reg, p2_reg, q2_reg;
    logic                    ovf0_reg;
    logic [CW-1:0]           iter_reg, count_reg;
    logic [11:0]             sum_r_reg, sum_g_reg, sum_b_reg;
    logic [mbs_pkg::RGB_W-1:0] hold_rgb_reg;
    logic                    out_vld_reg;
    logic [mbs_pkg::RGB_W-1:0] out_rgb_reg;
    logic                    out_ref_reg;

    mbs_pkg::mul_req_t       mreq_reg;
    mbs_pkg::mul_rsp_t       mrsp;

    logic [mbs_pkg::RGB_W-1:0] pal_mem [PALETTE_DEPTH];
    logic [mbs_pkg::RGB_W-1:0] pal_q_reg;
    logic                    pal_we;
    logic [PAL_AW-1:0]       pal_addr;

    logic [1:0]              ck, xi, yj, cn;
    logic                    caxis, corner, out_free, all_eq;
    logic [PIXEL_BITS-1:0]   cpix;
    logic signed [63:0]      cmult, corig, cval;
    logic [mbs_pkg::PITCH_W-1:0] cpitch;
    logic signed [65:0]      sum2, nrs, nis;
    logic [64:0]             mag2;
    logic [11:0]             avg_r, avg_g, avg_b;

    // cross product is held in nr_reg between the S multiply and ADD1
    function automatic logic signed [63:0] s_val();
        return nr_reg;
    endfunction

    mbs_fixmul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq_reg),
        .rsp   (mrsp)
    );

    always_comb
    begin
        ck     = cidx_reg[2:1];
        caxis  = cidx_reg[0];
        cpix   = caxis ? py_reg : px_reg;
        cpitch = caxis ? cfg.pitch_imag : cfg.pitch_real;
        corig  = $signed(caxis ? cfg.origin_imag : cfg.origin_real);
        cmult  = $signed(64'({cpix, 3'b000})) + 64'(mbs_pkg::sample_offset(ck));
        cval   = wrap_cb(64'(corig) + 64'(mrsp.res));
        xi     = refine_reg ? sidx_reg[3:2] : {sidx_reg[1], sidx_reg[1]};
        yj     = refine_reg ? sidx_reg[1:0] : {sidx_reg[0], sidx_reg[0]};
        corner = ((xi == 2'd0) || (xi == 2'd3)) && ((yj == 2'd0) || (yj == 2'd3));
        cn     = {xi[1], yj[1]};
        sum2   = sx66(s_val()) + sx66(s_val());
        nrs    = sx66(dq_reg) + sx66(cr_reg);
        nis    = sx66(s2_reg) + sx66(ci_reg);
        mag2   = {1'b0, p2_reg} + {1'b0, q2_reg};
        all_eq = (cnt_reg[0] == cnt_reg[1]) && (cnt_reg[1] == cnt_reg[2])
                 && (cnt_reg[2] == cnt_reg[3]);
        out_free = !out_vld_reg || m_tready;
        avg_r  = sum_r_reg + 12'd8;
        avg_g  = sum_g_reg + 12'd8;
        avg_b  = sum_b_reg + 12'd8;
        pal_addr = (CMP_W'(count_reg) > CMP_W'(PALETTE_DEPTH - 1))
                   ? PAL_AW'(PALETTE_DEPTH - 1) : PAL_AW'(count_reg);
        cmd_pop = (state_reg == ST_IDLE) && cmd_valid;
        pal_we  = cmd_pop && (cmd.kind == mbs_pkg::OP_LOAD) && cmd.idx_ok;
    end

    assign m_tvalid  = out_vld_reg;
    assign m_rgb     = out_rgb_reg;
    assign m_refined = out_ref_reg;

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[PAL_AW'(cmd.idx)] <= cmd.rgb;
        end
        pal_q_reg <= pal_mem[pal_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mop_reg      <= MOP_COORD;
            px_reg       <= '0;
            py_reg       <= '0;
            cidx_reg     <= 3'd0;
            for (int i = 0; i < 4; i++)
            begin
                xr_reg[i]  <= '0;
                yi_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
            refine_reg   <= 1'b0;
            sidx_reg     <= 4'd0;
            cr_reg       <= '0;
            ci_reg       <= '0;
            zr_reg       <= '0;
            zi_reg       <= '0;
            p_reg        <= '0;
            q_reg        <= '0;
            dq_reg       <= '0;
            s2_reg       <= '0;
            nr_reg       <= '0;
            ni_reg       <= '0;
            p2_reg       <= '0;
            q2_reg       <= '0;
            ovf0_reg     <= 1'b0;
            iter_reg     <= '0;
            count_reg    <= '0;
            sum_r_reg    <= '0;
            sum_g_reg    <= '0;
            sum_b_reg    <= '0;
            hold_rgb_reg <= '0;
            out_vld_reg  <= 1'b0;
            out_rgb_reg  <= '0;
            out_ref_reg  <= 1'b0;
            mreq_reg     <= '0;
        end
        else
        begin
            mreq_reg.go <= 1'b0;
            if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid && (cmd.kind == mbs_pkg::OP_RENDER))
                    begin
                        px_reg    <= cmd.px[PIXEL_BITS-1:0];
                        py_reg    <= cmd.py[PIXEL_BITS-1:0];
                        cidx_reg  <= 3'd0;
                        state_reg <= ST_CGO;
                    end
                end
                ST_CGO:
                begin
                    mreq_reg.go         <= 1'b1;
                    mreq_reg.coord_mode <= 1'b1;
                    mreq_reg.a          <= $signed({1'b0, cpitch});
                    mreq_reg.b          <= cmult;
                    mop_reg             <= MOP_COORD;
                    state_reg           <= ST_MWAIT;
                end
                ST_MWAIT:
                begin
                    if (mrsp.done)
                    begin
                        unique case (mop_reg)
                            MOP_COORD:
                            begin
                                if (caxis)
                                begin
                                    yi_reg[ck] <= cval;
                                end
                                else
                                begin
                                    xr_reg[ck] <= cval;
                                end
                                cidx_reg <= cidx_reg + 3'd1;
                                if (cidx_reg == 3'd7)
                                begin
                                    sidx_reg   <= 4'd0;
                                    refine_reg <= 1'b0;
                                    state_reg  <= ST_SNEXT;
                                end
                                else
                                begin
                                    state_reg <= ST_CGO;
                                end
                            end
                            MOP_P0:
                            begin
                                p_reg               <= mrsp.res;
                                ovf0_reg            <= mrsp.ovf;
                                mreq_reg.go         <= 1'b1;
                                mreq_reg.coord_mode <= 1'b0;
                                mreq_reg.a          <= zi_reg;
                                mreq_reg.b          <= zi_reg;
                                mop_reg             <= MOP_Q0;
                            end
                            MOP_Q0:
                            begin
                                q_reg     <= mrsp.res;
                                count_reg <= iter_reg;
                                state_reg <= (ovf0_reg || mrsp.ovf) ? ST_SDONE : ST_LOOPCHK;
                            end
                            MOP_S:
                            begin
                                nr_reg    <= mrsp.res;
                                count_reg <= iter_reg;
                                state_reg <= mrsp.ovf ? ST_SDONE : ST_ADD1;
                            end
                            MOP_P2:
                            begin
                                p2_reg    <= mrsp.res;
                                count_reg <= iter_reg;
                                if (mrsp.ovf)
                                begin
                                    state_reg <= ST_SDONE;
                                end
                                else
                                begin
                                    mreq_reg.go         <= 1'b1;
                                    mreq_reg.coord_mode <= 1'b0;
                                    mreq_reg.a          <= ni_reg;
                                    mreq_reg.b          <= ni_reg;
                                    mop_reg             <= MOP_Q2;
                                end
                            end
                            default:
                            begin
                                q2_reg    <= mrsp.res;
                                count_reg <= iter_reg;
                                state_reg <= mrsp.ovf ? ST_SDONE : ST_ESC;
                            end
                        endcase
                    end
                end
                ST_SNEXT:
                begin
                    if (refine_reg && corner)
                    begin
                        count_reg <= cnt_reg[cn];
                        state_reg <= ST_PREAD;
                    end
                    else
                    begin
                        cr_reg              <= xr_reg[xi];
                        ci_reg              <= yi_reg[yj];
                        zr_reg              <= xr_reg[xi];
                        zi_reg              <= yi_reg[yj];
                        iter_reg            <= '0;
                        mreq_reg.go         <= 1'b1;
                        mreq_reg.coord_mode <= 1'b0;
                        mreq_reg.a          <= xr_reg[xi];
                        mreq_reg.b          <= xr_reg[xi];
                        mop_reg             <= MOP_P0;
                        state_reg           <= ST_MWAIT;
                    end
                end
                ST_LOOPCHK:
                begin
                    count_reg <= iter_reg;
                    if (iter_reg >= cfg.max_iter)
                    begin
                        state_reg <= ST_SDONE;
                    end
                    else
                    begin
                        mreq_reg.go         <= 1'b1;
                        mreq_reg.coord_mode <= 1'b0;
                        mreq_reg.a          <= zr_reg;
                        mreq_reg.b          <= zi_reg;
                        mop_reg             <= MOP_S;
                        state_reg           <= ST_MWAIT;
                    end
                end
                ST_ADD1:
                begin
                    dq_reg <= p_reg - q_reg;
                    s2_reg <= sum2[63:0];
                    state_reg <= ((sum2 > CMAX66) || (sum2 < CMIN66)) ? ST_SDONE : ST_ADD2;
                end
                ST_ADD2:
                begin
                    nr_reg <= nrs[63:0];
                    ni_reg <= nis[63:0];
                    if ((nrs > CMAX66) || (nrs < CMIN66) || (nis > CMAX66) || (nis < CMIN66))
                    begin
                        state_reg <= ST_SDONE;
                    end
                    else
                    begin
                        mreq_reg.go         <= 1'b1;
                        mreq_reg.coord_mode <= 1'b0;
                        mreq_reg.a          <= nrs[63:0];
                        mreq_reg.b          <= nrs[63:0];
                        mop_reg             <= MOP_P2;
                        state_reg           <= ST_MWAIT;
                    end
                end
                ST_ESC:
                begin
                    if (mag2 > LIM10)
                    begin
                        state_reg <= ST_SDONE;
                    end
                    else
                    begin
                        zr_reg    <= nr_reg;
                        zi_reg    <= ni_reg;
                        p_reg     <= p2_reg;
                        q_reg     <= q2_reg;
                        iter_reg  <= iter_reg + CW'(1);
                        state_reg <= ST_LOOPCHK;
                    end
                end
                ST_SDONE:
                begin
                    if (refine_reg)
                    begin
                        state_reg <= ST_PREAD;
                    end
                    else
                    begin
                        cnt_reg[sidx_reg[1:0]] <= count_reg;
                        sidx_reg <= sidx_reg + 4'd1;
                        state_reg <= (sidx_reg == 4'd3) ? ST_CMP : ST_SNEXT;
                    end
                end
                ST_CMP:
                begin
                    if (all_eq)
                    begin
                        count_reg <= cnt_reg[0];
                        state_reg <= ST_PREAD;
                    end
                    else
                    begin
                        refine_reg <= 1'b1;
                        sidx_reg   <= 4'd0;
                        sum_r_reg  <= '0;
                        sum_g_reg  <= '0;
                        sum_b_reg  <= '0;
                        state_reg  <= ST_SNEXT;
                    end
                end
                ST_PREAD:
                begin
                    state_reg <= ST_PACC;
                end
                ST_PACC:
                begin
                    if (!refine_reg)
                    begin
                        hold_rgb_reg <= pal_q_reg;
                        state_reg    <= ST_OUTW;
                    end
                    else
                    begin
                        sum_r_reg <= sum_r_reg + 12'(pal_q_reg[23:16]);
                        sum_g_reg <= sum_g_reg + 12'(pal_q_reg[15:8]);
                        sum_b_reg <= sum_b_reg + 12'(pal_q_reg[7:0]);
                        sidx_reg  <= sidx_reg + 4'd1;
                        state_reg <= (sidx_reg == 4'd15) ? ST_OUTW : ST_SNEXT;
                    end
                end
                default:
                begin
                    if (out_free)
                    begin
                        out_vld_reg <= 1'b1;
                        out_ref_reg <= refine_reg;
                        out_rgb_reg <= refine_reg ? {avg_r[11:4], avg_g[11:4], avg_b[11:4]}
                                                  : hold_rgb_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    `MBS_ASSERT_HOLDS(a_done_in_wait, mrsp.done |-> (state_reg == ST_MWAIT))
    `MBS_ASSERT_HOLDS(a_iter_bound, (state_reg == ST_LOOPCHK) |-> (iter_reg <= cfg.max_iter))
    `MBS_ASSERT_HOLDS(a_cmp_corners, (state_reg == ST_CMP) |-> !refine_reg)
    `MBS_ASSERT_NEXT(a_go_waits, mreq_reg.go, (state_reg == ST_MWAIT) && !mrsp.done)

endmodule

`default_nettype wire

// File: rtl/core/mandelbrot_supersampled_pixel_top.sv
// Top level of the supersampled mandelbrot pixel colorer.
// Holds the config registers; instantiates mbs_front and mbs_back. Needs mbs_pkg.
//
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | tdata: pixel/palette fields, tuser: op
//  m_*      | out       | m_tvalid/m_tready  | tdata: red/green/blue, tuser: refined
//  cfg_*    | in        | cfg_wen            | cfg_index, cfg_data
//
// A render takes 4 or 16 samples; each escape iteration runs three fixed point
// products through the single shared multiplier of 32x32 partials.
// Reset is asynchronous, active low; palette contents are undefined until loaded.
// A two-entry command queue keeps accepting, until it is full, while the back end
// works or the result register waits on m_tready.
`default_nettype none

module mandelbrot_supersampled_pixel_top #(
    parameter int PALETTE_DEPTH = mbs_pkg::DEF_PALETTE_DEPTH,
    parameter int COORD_BITS    = mbs_pkg::DEF_COORD_BITS,
    parameter int PIXEL_BITS    = mbs_pkg::DEF_PIXEL_BITS,
    parameter int IN_TDW        = ((2 * PIXEL_BITS + 34 + 7) / 8) * 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // pixel_x, pixel_y, entry_index, entry_red, entry_green, entry_blue
    input  wire logic [IN_TDW-1:0]                 s_tdata,
    // op
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // red, green, blue
    output logic [23:0]                            m_tdata,
    // refined
    output logic                                   m_tuser,
    input  wire logic                              cfg_wen,
    input  wire logic [mbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PB = PIXEL_BITS;

    mbs_pkg::cfg_t cfg_reg;
    logic          cmd_valid, cmd_pop;
    mbs_pkg::cmd_t cmd;
    logic [mbs_pkg::RGB_W-1:0] out_rgb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_real <= '0;
            cfg_reg.origin_imag <= '0;
            cfg_reg.pitch_real  <= '0;
            cfg_reg.pitch_imag  <= '0;
            cfg_reg.max_iter    <= mbs_pkg::MAX_ITER_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                mbs_pkg::CFG_ORIGIN_REAL: cfg_reg.origin_real <= cfg_data;
                mbs_pkg::CFG_ORIGIN_IMAG: cfg_reg.origin_imag <= cfg_data;
                mbs_pkg::CFG_PITCH_REAL:
                    cfg_reg.pitch_real <= cfg_data[mbs_pkg::PITCH_W-1:0];
                mbs_pkg::CFG_PITCH_IMAG:
                    cfg_reg.pitch_imag <= cfg_data[mbs_pkg::PITCH_W-1:0];
                mbs_pkg::CFG_MAX_ITER:
                    cfg_reg.max_iter <= cfg_data[mbs_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    mbs_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .PIXEL_BITS    (PIXEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_px     (s_tdata[PB-1:0]),
        .in_py     (s_tdata[2*PB-1:PB]),
        .in_idx    (s_tdata[2*PB+9:2*PB]),
        .in_rgb    ({s_tdata[2*PB+17:2*PB+10], s_tdata[2*PB+25:2*PB+18],
                     s_tdata[2*PB+33:2*PB+26]}),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    mbs_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .COORD_BITS    (COORD_BITS),
        .PIXEL_BITS    (PIXEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_rgb     (out_rgb),
        .m_refined (m_tuser)
    );

    // palette order is red high; the stream carries red in the low byte
    assign m_tdata = {out_rgb[7:0], out_rgb[15:8], out_rgb[23:16]};

endmodule

`default_nettype wire
